// ----- rtl/fbwu_pkg.sv -----
// ----------------------------------------------------------------------------
// fbwu_pkg - shared types and constants of the framed bit-width unpacker
// Register indexes, reset values, field widths and controller/datapath links.
// ----------------------------------------------------------------------------
package fbwu_pkg;

	localparam int BYTE_W      = 8;
	localparam int BPV_W       = 6;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 6;

	localparam int VALUE_W = 63;
	localparam int PT_W    = 14;
	localparam int ETA_W   = 12;
	localparam int PHI_W   = 11;
	localparam int PID_W   = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_VALUE_WIDTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PLAIN_MODE  = 1'd1;

	localparam logic [BPV_W-1:0] BPV_RESET   = 6'd40;
	localparam logic             PLAIN_RESET = 1'b1;
	localparam logic [BPV_W-1:0] PLAIN_WIDTH = 6'd40;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_EXTRACT,
		ST_MARKER
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic emit_value;
		logic emit_marker;
	} dp_cmd_t;

	typedef struct packed {
		logic in_payload;
		logic count_last;
		logic count_zero;
		logic fill_ok;
		logic more_values;
		logic out_free;
	} dp_status_t;

endpackage

// ----- rtl/fbwu_byte_if.sv -----
// ----------------------------------------------------------------------------
// fbwu_byte_if - byte stream channel
// Valid/ready channel carrying one stream byte per request.
// ----------------------------------------------------------------------------
interface fbwu_byte_if;
	logic                         valid;
	logic                         ready;
	logic [fbwu_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- rtl/fbwu_result_if.sv -----
// ----------------------------------------------------------------------------
// fbwu_result_if - unpacked value channel
// Valid/ready channel carrying one unpacked value and its flags per request.
// ----------------------------------------------------------------------------
interface fbwu_result_if;
	logic                          valid;
	logic                          ready;
	logic [fbwu_pkg::VALUE_W-1:0]  unpacked_value;
	logic [fbwu_pkg::PT_W-1:0]     pt_code;
	logic [fbwu_pkg::ETA_W-1:0]    eta_code;
	logic [fbwu_pkg::PHI_W-1:0]    phi_code;
	logic [fbwu_pkg::PID_W-1:0]    pid_code;
	logic                          last_in_event;
	logic                          empty_event;
	logic                          width_error;

	modport source (output valid, output unpacked_value, output pt_code, output eta_code,
		output phi_code, output pid_code, output last_in_event, output empty_event,
		output width_error, input ready);
	modport sink (input valid, input unpacked_value, input pt_code, input eta_code,
		input phi_code, input pid_code, input last_in_event, input empty_event,
		input width_error, output ready);
endinterface

// ----- rtl/fbwu_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbwu_ctrl - sequencing state machine
// Takes a byte; the datapath emits its values one per cycle unless stalled.
// ----------------------------------------------------------------------------
module fbwu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fbwu_pkg::dp_status_t status,
	output fbwu_pkg::dp_cmd_t    cmd
);

	fbwu_pkg::state_t state_q;
	fbwu_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbwu_pkg::ST_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fbwu_pkg::ST_ACCEPT: begin
				if (in_valid) begin
					if (!status.in_payload) begin
						if (status.count_last && status.count_zero) begin
							state_nxt = fbwu_pkg::ST_MARKER;
						end
					end else if (status.fill_ok) begin
						state_nxt = fbwu_pkg::ST_EXTRACT;
					end
				end
			end
			fbwu_pkg::ST_EXTRACT: begin
				if (status.out_free && !status.more_values) begin
					state_nxt = fbwu_pkg::ST_ACCEPT;
				end
			end
			fbwu_pkg::ST_MARKER: begin
				if (status.out_free) begin
					state_nxt = fbwu_pkg::ST_ACCEPT;
				end
			end
			default: begin
				state_nxt = fbwu_pkg::ST_ACCEPT;
			end
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.take_byte   = 1'b0;
		cmd.emit_value  = 1'b0;
		cmd.emit_marker = 1'b0;
		case (state_q)
			fbwu_pkg::ST_ACCEPT: begin
				in_ready      = 1'b1;
				cmd.take_byte = in_valid;
			end
			fbwu_pkg::ST_EXTRACT: begin
				cmd.emit_value = status.out_free;
			end
			fbwu_pkg::ST_MARKER: begin
				cmd.emit_marker = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/fbwu_dp.sv -----
// ----------------------------------------------------------------------------
// fbwu_dp - count assembly, bit accumulator and output register
// Holds config, event count and packed bits; extracts one value per command.
// ----------------------------------------------------------------------------
module fbwu_dp #(
	parameter int COUNT_BYTES    = 4,
	parameter int MAX_VALUE_BITS = 63
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fbwu_pkg::dp_cmd_t                    cmd,
	output fbwu_pkg::dp_status_t                 status,
	input  logic [fbwu_pkg::BYTE_W-1:0]          data_byte,
	input  logic                                 cfg_write,
	input  logic [fbwu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fbwu_pkg::CFG_DATA_W-1:0]      cfg_data,
	fbwu_result_if.source                        result
);

	localparam int CNT_W     = fbwu_pkg::BYTE_W * COUNT_BYTES;
	localparam int CNT_IDX_W = (COUNT_BYTES > 1) ? $clog2(COUNT_BYTES) : 1;
	// held bits stay below the width before a byte lands, so width + 8 is enough
	localparam int ACC_W     = MAX_VALUE_BITS + fbwu_pkg::BYTE_W;
	localparam int HELD_W    = $clog2(ACC_W + 1);
	localparam int BPV_W     = fbwu_pkg::BPV_W;

	logic [BPV_W-1:0]     bpv_q;
	logic                 plain_q;
	logic                 in_payload_q;
	logic [CNT_IDX_W-1:0] cnt_idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [ACC_W-1:0]     acc_q;
	logic [HELD_W-1:0]    held_q;
	logic                 out_valid_q;

	logic [BPV_W-1:0]          w;
	logic [HELD_W-1:0]         w_h;
	logic [HELD_W-1:0]         held_fill;
	logic [HELD_W-1:0]         held_rest;
	logic [CNT_W-1:0]          cnt_full;
	logic [ACC_W-1:0]          byte_shifted;
	logic [ACC_W-1:0]          acc_masked;
	logic [MAX_VALUE_BITS-1:0] value;
	logic [63:0]               value64;
	logic                      width_err;

	// width in use: zero reads as one, large widths saturate
	always_comb begin
		if (bpv_q == '0) begin
			w = BPV_W'(1);
		end else if (bpv_q > BPV_W'(MAX_VALUE_BITS)) begin
			w = BPV_W'(MAX_VALUE_BITS);
		end else begin
			w = bpv_q;
		end
	end

	assign w_h       = HELD_W'(w);
	assign held_fill = held_q + HELD_W'(fbwu_pkg::BYTE_W);
	assign held_rest = held_q - w_h;

	always_comb begin
		for (int k = 0; k < COUNT_BYTES; k++) begin
			if (cnt_idx_q == CNT_IDX_W'(k)) begin
				cnt_full[k*fbwu_pkg::BYTE_W +: fbwu_pkg::BYTE_W] = data_byte;
			end else begin
				cnt_full[k*fbwu_pkg::BYTE_W +: fbwu_pkg::BYTE_W] =
					cnt_q[k*fbwu_pkg::BYTE_W +: fbwu_pkg::BYTE_W];
			end
		end
	end

	assign byte_shifted = ACC_W'(data_byte) << held_q;
	assign acc_masked   = acc_q & ~({ACC_W{1'b1}} << w);
	assign value        = acc_masked[MAX_VALUE_BITS-1:0];
	assign value64      = 64'(value);
	assign width_err    = plain_q && (w != fbwu_pkg::PLAIN_WIDTH);

	assign status.in_payload  = in_payload_q;
	assign status.count_last  = (cnt_idx_q == CNT_IDX_W'(COUNT_BYTES - 1));
	assign status.count_zero  = (cnt_full == '0);
	assign status.fill_ok     = (held_fill >= w_h);
	assign status.more_values = (held_rest >= w_h) && (rem_q != CNT_W'(1));
	assign status.out_free    = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpv_q        <= fbwu_pkg::BPV_RESET;
			plain_q      <= fbwu_pkg::PLAIN_RESET;
			in_payload_q <= 1'b0;
			cnt_idx_q    <= '0;
			cnt_q        <= '0;
			rem_q        <= '0;
			acc_q        <= '0;
			held_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				if (!in_payload_q) begin
					if (status.count_last) begin
						cnt_idx_q <= '0;
						cnt_q     <= '0;
						acc_q     <= '0;
						held_q    <= '0;
						if (!status.count_zero) begin
							rem_q        <= cnt_full;
							in_payload_q <= 1'b1;
						end
					end else begin
						cnt_idx_q <= cnt_idx_q + CNT_IDX_W'(1);
						cnt_q     <= cnt_full;
					end
				end else begin
					acc_q  <= acc_q | byte_shifted;
					held_q <= held_fill;
				end
			end
			if (cmd.emit_value) begin
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					// event done: padding bits go
					in_payload_q <= 1'b0;
					acc_q        <= '0;
					held_q       <= '0;
				end else begin
					acc_q  <= acc_q >> w;
					held_q <= held_rest;
				end
			end
			if (cfg_write && cfg_index == fbwu_pkg::REG_VALUE_WIDTH) begin
				bpv_q  <= cfg_data[BPV_W-1:0];
				acc_q  <= '0;
				held_q <= '0;
			end
			if (cfg_write && cfg_index == fbwu_pkg::REG_PLAIN_MODE) begin
				plain_q <= cfg_data[0];
			end
			if (cmd.emit_value || cmd.emit_marker) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_value) begin
			result.unpacked_value <= fbwu_pkg::VALUE_W'(value);
			result.pt_code        <= plain_q ? value64[13:0] : '0;
			result.eta_code       <= plain_q ? value64[25:14] : '0;
			result.phi_code       <= plain_q ? value64[36:26] : '0;
			result.pid_code       <= plain_q ? value64[39:37] : '0;
			result.last_in_event  <= (rem_q == CNT_W'(1));
			result.empty_event    <= 1'b0;
			result.width_error    <= width_err;
		end else if (cmd.emit_marker) begin
			result.unpacked_value <= '0;
			result.pt_code        <= '0;
			result.eta_code       <= '0;
			result.phi_code       <= '0;
			result.pid_code       <= '0;
			result.last_in_event  <= 1'b1;
			result.empty_event    <= 1'b1;
			result.width_error    <= width_err;
		end
	end

	a_emit_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_value |-> (held_q >= w_h) && (rem_q != '0))
		else $error("value extracted without enough bits or values");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !(cmd.emit_value || cmd.emit_marker))
		else $error("held result overwritten");

	a_idle_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_payload_q |-> (held_q == '0) && (acc_q == '0))
		else $error("bits held outside an event payload");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.empty_event) |->
			result.last_in_event && (result.unpacked_value == '0))
		else $error("empty event marker malformed");

endmodule

// ----- rtl/framed_bit_width_unpacker.sv -----
// ----------------------------------------------------------------------------
// framed_bit_width_unpacker - framed LSB-first variable-width value unpacker
// Splits a byte stream of counted events into fixed-width values and codes.
// ----------------------------------------------------------------------------
// Each event starts with COUNT_BYTES bytes of little-endian value count, then
// the values follow packed LSB first at the configured value width, padded
// to a byte boundary. A payload byte is first loaded into the bit
// accumulator, then each value it completes (0 to 8 values) is extracted in
// turn, and no new byte is taken until they are out; the result side can
// hold off any value. The single barrel extractor behind the output
// register delivers at most one value per cycle. A zero count gives one
// marker request (last_in_event and empty_event set) through the marker
// state once the output register is free, and no byte is taken until the
// marker sits in the output register. In plain mode each value is also split
// into pt/eta/phi/pid codes and a width other than 40 raises width_error.
// Writing the value width register discards any partly assembled value;
// write config only when the block is idle.
// ----------------------------------------------------------------------------
module framed_bit_width_unpacker #(
	parameter int COUNT_BYTES    = 4,
	parameter int MAX_VALUE_BITS = 63
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fbwu_byte_if.sink                         stream,
	fbwu_result_if.source                     result,
	input  logic                              cfg_write,
	input  logic [fbwu_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fbwu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	fbwu_pkg::dp_cmd_t    cmd;
	fbwu_pkg::dp_status_t status;
	logic                 in_ready;

	// a byte request is taken only between extraction runs
	assign stream.ready = in_ready;

	fbwu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath owns the accumulator, the count and the result register
	fbwu_dp #(
		.COUNT_BYTES    (COUNT_BYTES),
		.MAX_VALUE_BITS (MAX_VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.data_byte (stream.data_byte),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

// ----- verif/tb_framed_bit_width_unpacker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_bit_width_unpacker - self-checking bench for the framed unpacker
// Sends counted events as a byte stream and tracks the expected values and
// flags in a scoreboard. Each result request is then checked field by field.
// ----------------------------------------------------------------------------
module tb_framed_bit_width_unpacker;

	localparam int COUNT_BYTES  = 4;
	localparam int RANDOM_BYTES = 380;
	localparam int SETTLE_CYCLES = 12;        // slack for a payload byte still in the block
	localparam int LIMIT_CYCLES  = 2_000_000;

	// Widths tried first in the random part: reset value, both extremes, zero
	// (taken as one), the byte width and one below it, and the neighbours of the plain width.
	localparam logic [fbwu_pkg::BPV_W-1:0] WIDTH_PLAN [0:7] =
		'{6'd40, 6'd1, 6'd63, 6'd0, 6'd8, 6'd39, 6'd41, 6'd7};

	// One result request, kept 4-state so that X on the outputs is caught
	typedef struct {
		logic [fbwu_pkg::VALUE_W-1:0] value;
		logic [fbwu_pkg::PT_W-1:0]    pt;
		logic [fbwu_pkg::ETA_W-1:0]   eta;
		logic [fbwu_pkg::PHI_W-1:0]   phi;
		logic [fbwu_pkg::PID_W-1:0]   pid;
		logic                         last;
		logic                         empty;
		logic                         werr;
	} unpacked_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirrors the unpacker state and queues the values each
	// accepted byte should release, then matches them against the output.
	// ------------------------------------------------------------------------
	class unpack_scoreboard;
		bit [fbwu_pkg::BPV_W-1:0] val_width;
		bit             plain_mode;
		bit             in_payload;
		int unsigned    count_idx;
		bit [31:0]      count_acc;
		bit [31:0]      values_left;
		bit [71:0]      acc;          // 64 + 8 bits, so wide values keep their top bits
		int unsigned    held;
		unpacked_t      pending_q[$];
		int unsigned    fails;

		function void drop_held();
			acc  = '0;
			held = 0;
		endfunction

		function void restart();
			val_width      = fbwu_pkg::BPV_RESET;
			plain_mode     = fbwu_pkg::PLAIN_RESET;
			in_payload     = 1'b0;
			count_idx      = 0;
			count_acc      = '0;
			values_left    = '0;
			drop_held();
			pending_q.delete();
		endfunction

		function int unsigned value_width();
			return (val_width == 0) ? 1 : val_width;
		endfunction

		function void write_reg(logic [fbwu_pkg::CFG_INDEX_W-1:0] idx,
				logic [fbwu_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fbwu_pkg::REG_VALUE_WIDTH: begin
					val_width = data;
					drop_held();
				end
				fbwu_pkg::REG_PLAIN_MODE: plain_mode = data[0];
				default: ;
			endcase
		endfunction

		function void push_result(bit [63:0] v, bit last, bit empty, int unsigned w);
			unpacked_t r;
			r.value = v[fbwu_pkg::VALUE_W-1:0];
			r.pt    = plain_mode ? v[13:0]  : '0;
			r.eta   = plain_mode ? v[25:14] : '0;
			r.phi   = plain_mode ? v[36:26] : '0;
			r.pid   = plain_mode ? v[39:37] : '0;
			r.last  = last;
			r.empty = empty;
			r.werr  = plain_mode && (w != fbwu_pkg::PLAIN_WIDTH);
			pending_q.insert(pending_q.size(), r);
		endfunction

		function void note_byte(bit [7:0] b);
			int unsigned w;
			bit [31:0]   total;
			bit [71:0]   mask;
			w = value_width();
			if (!in_payload) begin
				// little-endian count, one byte per request
				count_acc |= {24'd0, b} << (8 * count_idx);
				if (count_idx == COUNT_BYTES - 1) begin
					total     = count_acc;
					count_idx = 0;
					count_acc = '0;
					drop_held();
					if (total == 0) begin
						push_result('0, 1'b1, 1'b1, w);
					end else begin
						values_left = total;
						in_payload  = 1'b1;
					end
				end else begin
					count_idx++;
				end
				return;
			end
			acc  |= {64'd0, b} << held;
			held += 8;
			mask  = (72'd1 << w) - 72'd1;
			while (held >= w && values_left > 0) begin
				values_left--;
				push_result(64'(acc & mask), values_left == 0, 1'b0, w);
				acc  >>= w;
				held -= w;
			end
			// end of event: padding bits of this byte are thrown away
			if (values_left == 0) begin
				in_payload = 1'b0;
				drop_held();
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
			if (seen !== want) begin
				fails++;
				$error("%s: expected %0h, got %0h", name, want, seen);
			end
		endfunction

		function void check_result(unpacked_t got);
			unpacked_t want;
			if (pending_q.size() == 0) begin
				fails++;
				$error("result request with nothing pending: unpacked_value %0h", got.value);
				return;
			end
			want = pending_q.pop_front();
			compare_field("unpacked_value", 64'(want.value), 64'(got.value));
			compare_field("pt_code", 64'(want.pt), 64'(got.pt));
			compare_field("eta_code", 64'(want.eta), 64'(got.eta));
			compare_field("phi_code", 64'(want.phi), 64'(got.phi));
			compare_field("pid_code", 64'(want.pid), 64'(got.pid));
			compare_field("last_in_event", 64'(want.last), 64'(got.last));
			compare_field("empty_event", 64'(want.empty), 64'(got.empty));
			compare_field("width_error", 64'(want.werr), 64'(got.werr));
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block itself
	// ------------------------------------------------------------------------
	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write;
	logic [fbwu_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [fbwu_pkg::CFG_DATA_W-1:0]  cfg_data;

	fbwu_byte_if   stream_ch ();
	fbwu_result_if result_ch ();

	framed_bit_width_unpacker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	unpack_scoreboard sb = new();

	int          source_gap_pct;   // chance of a gap before a byte request
	int          sink_stall_pct;   // chance of a stall on the result side
	int unsigned stall_left;
	int unsigned bytes_sent;
	int unsigned cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Short gaps mostly, now and then a long one
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pace(int unsigned sel);
		case (sel % 3)
			0: return 0;
			1: return 25;
			default: return 60;
		endcase
	endfunction

	function automatic bit [7:0] payload_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'h00;
		if (r < 20)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly short events; some empty ones; a count above 255 only at
	// narrow widths, where it stays at most 132 bytes long.
	function automatic bit [31:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		if (r < 20 && sb.value_width() <= 4)
			return 256 + $urandom_range(0, 7);
		if (sb.value_width() <= 16)
			return $urandom_range(1, 12);
		return $urandom_range(1, 4);
	endfunction

	// Result side: random stalls, driven on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready = 1'b0;
			stall_left      = 0;
		end else if (stall_left > 0) begin
			result_ch.ready = 1'b0;
			stall_left--;
		end else begin
			result_ch.ready = 1'b1;
			if ($urandom_range(0, 99) < sink_stall_pct)
				stall_left = pick_gap();
		end
	end

	// Every accepted result request goes to the scoreboard
	always @(posedge clk) begin : collect
		unpacked_t seen;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.value = result_ch.unpacked_value;
			seen.pt    = result_ch.pt_code;
			seen.eta   = result_ch.eta_code;
			seen.phi   = result_ch.phi_code;
			seen.pid   = result_ch.pid_code;
			seen.last  = result_ch.last_in_event;
			seen.empty = result_ch.empty_event;
			seen.werr  = result_ch.width_error;
			sb.check_result(seen);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// One byte request, with an optional gap in front; the scoreboard is
	// told at the edge that accepts it.
	task automatic send_byte(bit [7:0] b);
		int unsigned gap;
		gap = ($urandom_range(0, 99) < source_gap_pct) ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			stream_ch.valid = 1'b0;
		end
		@(negedge clk);
		stream_ch.valid     = 1'b1;
		stream_ch.data_byte = b;
		do
			@(posedge clk);
		while (!stream_ch.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Stop sending, let every pending value come out, then give the block
	// time to finish a byte that released nothing.
	task automatic settle();
		@(negedge clk);
		stream_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [fbwu_pkg::CFG_INDEX_W-1:0] idx,
			logic [fbwu_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_write = 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic send_count(bit [31:0] count);
		for (int i = 0; i < COUNT_BYTES; i++)
			send_byte(count[8*i +: 8]);
	endtask

	// A whole event with random payload. The payload length comes from the
	// scoreboard, so the stream stays in frame whatever the width. A split
	// event (short counts only) pauses after a few payload bytes and changes
	// the width, which throws away the bits held so far but keeps the count.
	task automatic send_event(bit [31:0] count, bit split);
		int unsigned payload_sent;
		int unsigned split_at;
		payload_sent = 0;
		split_at     = $urandom_range(1, 3);
		send_count(count);
		while (sb.in_payload) begin
			if (split && count < 256 && payload_sent == split_at) begin
				settle();
				write_reg(fbwu_pkg::REG_VALUE_WIDTH, 6'($urandom_range(0, 63)));
			end
			send_byte(payload_byte());
			payload_sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned     phase;
		int unsigned     random_start;
		logic [fbwu_pkg::BPV_W-1:0] width;
		arst_n              = 1'b0;
		cfg_write           = 1'b0;
		cfg_index           = fbwu_pkg::REG_VALUE_WIDTH;
		cfg_data            = '0;
		stream_ch.valid     = 1'b0;
		stream_ch.data_byte = '0;
		source_gap_pct      = 0;
		sink_stall_pct      = 0;
		bytes_sent          = 0;
		sb.restart();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings (width 40, plain): one all-ones value, so every
		// code sits at its maximum, then an empty event marker.
		send_count(1);
		repeat (5) send_byte(8'hFF);
		send_count(0);

		// Widest value, plain mode left on so width_error is raised; the
		// eighth byte carries one padding bit that must be dropped.
		settle();
		write_reg(fbwu_pkg::REG_VALUE_WIDTH, 6'd63);
		send_count(1);
		repeat (8) send_byte(8'hFF);

		// Width zero is taken as one: a single byte releases eight values,
		// pass-through mode so all codes read zero.
		settle();
		write_reg(fbwu_pkg::REG_VALUE_WIDTH, 6'd0);
		write_reg(fbwu_pkg::REG_PLAIN_MODE, 6'd0);
		send_count(8);
		send_byte(8'hA5);

		// Random phases: new settings and pacing each time. Pacing steps
		// through every mix of none, light and heavy idling on both sides.
		phase        = 0;
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			settle();
			width = (phase < 8) ? WIDTH_PLAN[phase[2:0]] : 6'($urandom_range(0, 63));
			write_reg(fbwu_pkg::REG_VALUE_WIDTH, width);
			write_reg(fbwu_pkg::REG_PLAIN_MODE,
				(phase < 4) ? 6'(phase[0]) : 6'($urandom_range(0, 1)));
			source_gap_pct = pace(phase);
			sink_stall_pct = pace(phase / 3);
			repeat (4)
				send_event(pick_count(), $urandom_range(0, 99) < 15);
			phase++;
		end

		settle();
		if (sb.pending() != 0)
			sb.fails++;
		if (sb.fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fbwu_pkg.sv
rtl/fbwu_byte_if.sv
rtl/fbwu_result_if.sv
rtl/fbwu_ctrl.sv
rtl/fbwu_dp.sv
rtl/framed_bit_width_unpacker.sv
verif/tb_framed_bit_width_unpacker.sv
